// ===== rtl/core/bl2led_pkg.sv =====
// ----------------------------------------------------------------------------
// bl2led_pkg
// Shared types, constants and helper functions for the line-to-LED engine.
// ----------------------------------------------------------------------------
package bl2led_pkg;

    // Matrix geometry.
    localparam int MATRIX_WIDTH  = 16;
    localparam int MATRIX_HEIGHT = 16;

    // Coordinate format and the window that endpoints are clamped to.
    localparam int COORD_W = 7;
    localparam logic signed [COORD_W-1:0] COORD_LOW  = -7'sd16;
    localparam logic signed [COORD_W-1:0] COORD_HIGH = 7'sd47;

    // Error term of the walk; wide enough for every reachable value.
    localparam int FRAC_W = 10;

    // Microcode program counter and step addresses.
    typedef logic [1:0] t_pc;
    localparam t_pc PC_WAIT  = 2'd0;
    localparam t_pc PC_SETUP = 2'd1;
    localparam t_pc PC_FIRST = 2'd2;
    localparam t_pc PC_WALK  = 2'd3;

    // Branch conditions of a control word.
    typedef logic [1:0] t_cond;
    localparam t_cond COND_ALWAYS = 2'd0;
    localparam t_cond COND_START  = 2'd1;
    localparam t_cond COND_LAST   = 2'd2;

    // One control word of the sequencer program.
    typedef struct packed {
        logic  busy;
        logic  load;
        logic  setup;
        logic  emit_first;
        logic  walk;
        t_cond cond;
        t_pc   tgt_true;
        t_pc   tgt_false;
    } t_ctrl;

    // Pixel mapping result.
    typedef struct packed {
        logic       visible;
        logic [7:0] led_index;
    } t_pix;

    // Clamp a raw signed coordinate into the legal window.
    function automatic logic signed [COORD_W-1:0] sat_coord(logic [COORD_W-1:0] raw);
        logic signed [COORD_W-1:0] v;
        v = $signed(raw);
        if (v < COORD_LOW) begin
            return COORD_LOW;
        end
        if (v > COORD_HIGH) begin
            return COORD_HIGH;
        end
        return v;
    endfunction

    // Clip a pixel to the matrix and map it to its serpentine LED position.
    function automatic t_pix map_pixel(logic signed [COORD_W-1:0] x,
                                       logic signed [COORD_W-1:0] y);
        t_pix p;
        int   col;
        int   row;
        int   idx;
        col = int'(x);
        row = int'(y);
        p.visible = (col >= 0) && (col < MATRIX_WIDTH) &&
                    (row >= 0) && (row < MATRIX_HEIGHT);
        if (x[0]) begin
            row = MATRIX_HEIGHT - 1 - row;
        end
        idx = col * MATRIX_HEIGHT + row;
        p.led_index = idx[7:0];
        return p;
    endfunction

endpackage

// ===== rtl/core/bl2led_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// bl2led_ucode_rom
// Read-only control store: one control word for each program step.
// ----------------------------------------------------------------------------
module bl2led_ucode_rom (
    input  bl2led_pkg::t_pc   i_pc,
    output bl2led_pkg::t_ctrl o_ctrl
);
    import bl2led_pkg::*;

    // Fields: busy, load, setup, emit_first, walk, cond, target if true, else.
    always_comb begin
        case (i_pc)
            PC_WAIT:  o_ctrl = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                                 COND_START, PC_SETUP, PC_WAIT};
            PC_SETUP: o_ctrl = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                                 COND_ALWAYS, PC_FIRST, PC_FIRST};
            PC_FIRST: o_ctrl = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
                                 COND_LAST, PC_WAIT, PC_WALK};
            PC_WALK:  o_ctrl = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
                                 COND_LAST, PC_WAIT, PC_WALK};
            default:  o_ctrl = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                 COND_ALWAYS, PC_WAIT, PC_WAIT};
        endcase
    end

endmodule

// ===== rtl/core/bresenham_line_to_serpentine_leds.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_to_serpentine_leds
// Walks an integer Bresenham line and emits one serpentine LED pixel per step.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                     Payload
// --------  ---------  ----------------------------  ---------------------------
// command   in         start high while busy low     endpoints, RGB color
// pixel     out        o_valid strobe, one cycle     LED index, visible, RGB, last
//
// After the accepting edge the engine stays busy through a setup step and then
// through the walk, one pixel per cycle from the single step unit (an update
// of the error term and a step of one or both coordinates per pixel), up to
// the longest line of 64 pixels. The next command is taken in the cycle in
// which the last pixel is shown. Reset is synchronous and active low; it
// returns the sequencer to its wait step and drops the strobe. The receiver
// cannot stall the pixel stream.
//
// Control is a four-step microprogram in bl2led_ucode_rom. Each control word
// selects which datapath action runs this cycle (load, setup, first pixel,
// walk step) and a branch: always taken, wait for start, or leave the walk
// loop once the last pixel is produced.
// ----------------------------------------------------------------------------
module bresenham_line_to_serpentine_leds (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic signed [6:0] i_start_x,
    input  logic signed [6:0] i_start_y,
    input  logic signed [6:0] i_end_x,
    input  logic signed [6:0] i_end_y,
    input  logic [7:0]        i_color_red,
    input  logic [7:0]        i_color_green,
    input  logic [7:0]        i_color_blue,
    output logic              o_valid,
    output logic [7:0]        o_led_index,
    output logic              o_visible,
    output logic [7:0]        o_out_red,
    output logic [7:0]        o_out_green,
    output logic [7:0]        o_out_blue,
    output logic              o_last_pixel
);
    import bl2led_pkg::*;

    // Sequencer.
    t_pc   r_pc;
    t_pc   n_pc;
    t_ctrl s_ctrl;
    logic  s_cond;
    logic  s_last;

    // Datapath registers: current point, end point, walk setup and color.
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_xe;
    logic signed [COORD_W-1:0] r_ye;
    logic                      r_sx_neg;
    logic                      r_sy_neg;
    logic                      r_xmaj;
    logic [7:0]                r_dmaj2;
    logic [7:0]                r_dmin2;
    logic [FRAC_W-1:0]         r_frac;
    logic [7:0]                r_red;
    logic [7:0]                r_green;
    logic [7:0]                r_blue;

    // Output register.
    logic       r_valid;
    logic [7:0] r_led;
    logic       r_vis;
    logic [7:0] r_out_red;
    logic [7:0] r_out_green;
    logic [7:0] r_out_blue;
    logic       r_last;

    // Setup arithmetic.
    logic signed [COORD_W:0] s_dx;
    logic signed [COORD_W:0] s_dy;
    logic [COORD_W-1:0]      s_adx;
    logic [COORD_W-1:0]      s_ady;
    logic                    s_xmaj;
    logic [FRAC_W-1:0]       s_frac0;

    // Walk step arithmetic.
    logic                      s_minor;
    logic                      s_step_x;
    logic                      s_step_y;
    logic signed [COORD_W-1:0] s_nx;
    logic signed [COORD_W-1:0] s_ny;
    logic [FRAC_W-1:0]         s_nfrac;
    logic                      s_walk_last;
    logic                      s_first_last;

    // Pixel that leaves this cycle, before clipping is applied to the payload.
    logic signed [COORD_W-1:0] s_px;
    logic signed [COORD_W-1:0] s_py;
    t_pix                      s_pix;
    logic                      s_emit;

    bl2led_ucode_rom u_rom (
        .i_pc   (r_pc),
        .o_ctrl (s_ctrl)
    );

    assign busy = s_ctrl.busy;

    // Setup: absolute deltas, step directions and the initial error term.
    always_comb begin
        s_dx  = {r_xe[COORD_W-1], r_xe} - {r_x[COORD_W-1], r_x};
        s_dy  = {r_ye[COORD_W-1], r_ye} - {r_y[COORD_W-1], r_y};
        s_adx = s_dx[COORD_W] ? COORD_W'(-s_dx) : s_dx[COORD_W-1:0];
        s_ady = s_dy[COORD_W] ? COORD_W'(-s_dy) : s_dy[COORD_W-1:0];
        // Ties go to the y-major walk.
        s_xmaj = s_adx > s_ady;
        if (s_xmaj) begin
            s_frac0 = {2'b00, s_ady, 1'b0} - {3'b000, s_adx};
        end else begin
            s_frac0 = {2'b00, s_adx, 1'b0} - {3'b000, s_ady};
        end
    end

    // One Bresenham step: the major axis always moves, the minor axis moves
    // when the error term is not negative.
    always_comb begin
        s_minor  = !r_frac[FRAC_W-1];
        s_step_x = r_xmaj || s_minor;
        s_step_y = !r_xmaj || s_minor;
        s_nx = s_step_x ? (r_sx_neg ? r_x - 7'sd1 : r_x + 7'sd1) : r_x;
        s_ny = s_step_y ? (r_sy_neg ? r_y - 7'sd1 : r_y + 7'sd1) : r_y;
        s_nfrac = r_frac - (s_minor ? {2'b00, r_dmaj2} : {FRAC_W{1'b0}})
                + {2'b00, r_dmin2};
        s_walk_last  = r_xmaj ? (s_nx == r_xe) : (s_ny == r_ye);
        s_first_last = (r_x == r_xe) && (r_y == r_ye);
    end

    // The first pixel is the start point itself; walk steps show the new point.
    always_comb begin
        s_px   = s_ctrl.walk ? s_nx : r_x;
        s_py   = s_ctrl.walk ? s_ny : r_y;
        s_pix  = map_pixel(s_px, s_py);
        s_emit = s_ctrl.emit_first || s_ctrl.walk;
        s_last = s_ctrl.walk ? s_walk_last : s_first_last;
    end

    // Branch resolution of the current control word.
    always_comb begin
        case (s_ctrl.cond)
            COND_ALWAYS: s_cond = 1'b1;
            COND_START:  s_cond = start;
            COND_LAST:   s_cond = s_last;
            default:     s_cond = 1'b0;
        endcase
        n_pc = s_cond ? s_ctrl.tgt_true : s_ctrl.tgt_false;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= PC_WAIT;
            r_valid <= 1'b0;
        end else begin
            r_pc    <= n_pc;
            r_valid <= s_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ctrl.load && start) begin
            r_x     <= sat_coord(i_start_x);
            r_y     <= sat_coord(i_start_y);
            r_xe    <= sat_coord(i_end_x);
            r_ye    <= sat_coord(i_end_y);
            r_red   <= i_color_red;
            r_green <= i_color_green;
            r_blue  <= i_color_blue;
        end
        if (s_ctrl.setup) begin
            r_sx_neg <= s_dx[COORD_W];
            r_sy_neg <= s_dy[COORD_W];
            r_xmaj   <= s_xmaj;
            r_dmaj2  <= s_xmaj ? {s_adx, 1'b0} : {s_ady, 1'b0};
            r_dmin2  <= s_xmaj ? {s_ady, 1'b0} : {s_adx, 1'b0};
            r_frac   <= s_frac0;
        end
        if (s_ctrl.walk) begin
            r_x    <= s_nx;
            r_y    <= s_ny;
            r_frac <= s_nfrac;
        end
        // Off-screen pixels carry a cleared index and color.
        r_led       <= s_pix.visible ? s_pix.led_index : 8'd0;
        r_vis       <= s_pix.visible;
        r_out_red   <= s_pix.visible ? r_red : 8'd0;
        r_out_green <= s_pix.visible ? r_green : 8'd0;
        r_out_blue  <= s_pix.visible ? r_blue : 8'd0;
        r_last      <= s_last;
    end

    assign o_valid      = r_valid;
    assign o_led_index  = r_led;
    assign o_visible    = r_vis;
    assign o_out_red    = r_out_red;
    assign o_out_green  = r_out_green;
    assign o_out_blue   = r_out_blue;
    assign o_last_pixel = r_last;

    // A pixel is only produced by the first-pixel or walk steps.
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_pc) == PC_FIRST || $past(r_pc) == PC_WALK))
        else $error("pixel strobe without an emitting step");

    // The engine goes idle exactly when the last pixel of a line is shown.
    a_idle_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_pixel) |-> !busy)
        else $error("engine still busy after the last pixel");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_valid && o_last_pixel))
        else $error("engine went idle without a last pixel");

    // An accepted command always starts a run.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start a run");

    // Clipped pixels leave no trace in the payload.
    a_clip_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_visible) |-> (o_led_index == 8'd0 && o_out_red == 8'd0 &&
                                     o_out_green == 8'd0 && o_out_blue == 8'd0))
        else $error("off-screen pixel carries data");

endmodule
